### rtl/pnm_hdr_pkg.sv
package pnm_hdr_pkg;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EOF   = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  typedef enum logic [2:0] {
    ST_PARSING    = 3'd0,
    ST_COMPLETE   = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_NOT_PNM    = 3'd3,
    ST_BAD_TYPE   = 3'd4,
    ST_EOF_NUMBER = 3'd5,
    ST_IGNORED    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    PH_LETTER = 3'd0,
    PH_TYPE   = 3'd1,
    PH_SKIP   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] CHAN_GREY  = 2'd1;
  localparam logic [1:0] CHAN_COLOR = 2'd3;

  localparam logic [30:0] MAX_LIMIT = 31'h7fffffff;
  localparam logic [30:0] LIM_2B    = 31'd256;
  localparam logic [30:0] LIM_4B    = 31'd65536;

  localparam logic [2:0] VB_ONE  = 3'd1;
  localparam logic [2:0] VB_TWO  = 3'd2;
  localparam logic [2:0] VB_FOUR = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } hdr_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [30:0] max_value;
    logic [1:0]  channels;
    logic [2:0]  value_bytes;
  } hdr_result_t;

  function automatic logic [2:0] value_bytes_of(input logic [30:0] m);
    logic [2:0] vb;
    if (m >= LIM_4B) begin
      vb = VB_FOUR;
    end else if (m >= LIM_2B) begin
      vb = VB_TWO;
    end else begin
      vb = VB_ONE;
    end
    return vb;
  endfunction

endpackage

### rtl/pnm_hdr_in_stage.sv
module pnm_hdr_in_stage
  import pnm_hdr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  hdr_item_t item,
  input  logic      take,
  output logic      held_valid,
  output hdr_item_t held
);

  assign item_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

endmodule

### rtl/pnm_hdr_core.sv
module pnm_hdr_core
  import pnm_hdr_pkg::*;
#(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  hdr_item_t   item,
  output hdr_result_t res
);

  localparam int NW = NUMBER_WIDTH;
  localparam int CW = (NUMBER_WIDTH > 32) ? NUMBER_WIDTH : 32;

  phase_t         phase, phase_next;
  logic [1:0]     idx, idx_next;
  logic           in_comment, in_comment_next;
  logic [NW-1:0]  acc, acc_next;
  logic [NW-1:0]  width_reg, width_next;
  logic [NW-1:0]  height_reg, height_next;
  logic [30:0]    max_reg, max_next;
  logic [1:0]     channel_reg, channel_next;
  status_t        status;

  logic           is_data, is_eof, is_start;
  logic           is_digit, is_space, is_hash, is_lf;
  logic           skip_fin, dig_fin, idx_last, do_finish;
  logic [NW-1:0]  dval, acc_mul, fin_val;
  logic [CW-1:0]  fin_ext, w_ext, h_ext;
  logic [30:0]    fin_sat;

  assign is_data  = (item.kind == KIND_DATA);
  assign is_eof   = (item.kind == KIND_EOF);
  assign is_start = (item.kind == KIND_START);
  assign is_digit = (item.data_byte >= CH_ZERO) && (item.data_byte <= CH_NINE);
  assign is_space = (item.data_byte == CH_SPACE) ||
                    ((item.data_byte >= CH_TAB) && (item.data_byte <= CH_CR));
  assign is_hash  = (item.data_byte == CH_HASH);
  assign is_lf    = (item.data_byte == CH_LF);

  // non-digit where a number starts: number is 0, byte consumed
  assign skip_fin = is_data && !is_hash && !in_comment && !is_space && !is_digit;
  assign dig_fin  = !(is_data && is_digit);
  assign idx_last = idx[1];

  assign dval    = NW'(item.data_byte[3:0]);
  assign acc_mul = (acc << 3) + (acc << 1) + dval;
  assign fin_val = (phase == PH_DIGITS) ? acc : '0;
  assign fin_ext = CW'(fin_val);
  assign fin_sat = (fin_ext > CW'(MAX_LIMIT)) ? MAX_LIMIT : fin_ext[30:0];

  always_comb begin
    phase_next = phase;
    if (is_start) begin
      phase_next = PH_LETTER;
    end else if (is_data || is_eof) begin
      case (phase)
        PH_LETTER: begin
          phase_next = (is_eof || item.data_byte != CH_P) ? PH_DONE : PH_TYPE;
        end
        PH_TYPE: begin
          phase_next = (is_data && (item.data_byte == CH_5 || item.data_byte == CH_6))
                       ? PH_SKIP : PH_DONE;
        end
        PH_SKIP: begin
          if (is_eof) begin
            phase_next = PH_DONE;
          end else if (skip_fin) begin
            phase_next = idx_last ? PH_DONE : PH_SKIP;
          end else if (!is_hash && !in_comment && !is_space && is_digit) begin
            phase_next = PH_DIGITS;
          end
        end
        PH_DIGITS: begin
          if (dig_fin) begin
            phase_next = (idx_last || is_eof) ? PH_DONE : PH_SKIP;
          end
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end
  end

  always_comb begin
    idx_next        = idx;
    in_comment_next = in_comment;
    acc_next        = acc;
    width_next      = width_reg;
    height_next     = height_reg;
    max_next        = max_reg;
    channel_next    = channel_reg;
    status          = ST_PARSING;
    do_finish       = 1'b0;
    if (is_start) begin
      idx_next        = '0;
      in_comment_next = 1'b0;
      acc_next        = '0;
      width_next      = '0;
      height_next     = '0;
      max_next        = '0;
      channel_next    = '0;
    end else if (!(is_data || is_eof)) begin
      status = ST_IGNORED;
    end else begin
      case (phase)
        PH_LETTER: begin
          if (is_eof) begin
            status = ST_EMPTY;
          end else if (item.data_byte != CH_P) begin
            status = ST_NOT_PNM;
          end
        end
        PH_TYPE: begin
          if (is_data && item.data_byte == CH_5) begin
            channel_next = CHAN_GREY;
          end else if (is_data && item.data_byte == CH_6) begin
            channel_next = CHAN_COLOR;
          end else begin
            status = ST_BAD_TYPE;
          end
          idx_next        = '0;
          in_comment_next = 1'b0;
          acc_next        = '0;
        end
        PH_SKIP: begin
          if (is_eof) begin
            status = ST_EOF_NUMBER;
          end else if (is_hash) begin
            in_comment_next = 1'b1;
          end else if (in_comment) begin
            if (is_lf) begin
              in_comment_next = 1'b0;
            end
          end else if (is_space) begin
            in_comment_next = in_comment;
          end else if (is_digit) begin
            acc_next = dval;
          end else begin
            do_finish = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (dig_fin) begin
            do_finish = 1'b1;
          end else begin
            acc_next = acc_mul;
          end
        end
        default: begin
          status = ST_IGNORED;
        end
      endcase
      if (do_finish) begin
        acc_next        = '0;
        in_comment_next = 1'b0;
        if (idx_last) begin
          max_next = fin_sat;
          status   = ST_COMPLETE;
        end else begin
          if (idx == 2'd0) begin
            width_next = fin_val;
          end else begin
            height_next = fin_val;
          end
          idx_next = idx + 2'd1;
          if (is_eof) begin
            status = ST_EOF_NUMBER;
          end
        end
      end
    end
  end

  assign w_ext = CW'(width_next);
  assign h_ext = CW'(height_next);

  always_comb begin
    res        = '0;
    res.status = status;
    if (status == ST_COMPLETE) begin
      res.image_width  = w_ext[31:0];
      res.image_height = h_ext[31:0];
      res.max_value    = max_next;
      res.channels     = channel_next;
      res.value_bytes  = value_bytes_of(max_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LETTER;
      idx         <= '0;
      in_comment  <= 1'b0;
      acc         <= '0;
      width_reg   <= '0;
      height_reg  <= '0;
      max_reg     <= '0;
      channel_reg <= '0;
    end else if (go) begin
      phase       <= phase_next;
      idx         <= idx_next;
      in_comment  <= in_comment_next;
      acc         <= acc_next;
      width_reg   <= width_next;
      height_reg  <= height_next;
      max_reg     <= max_next;
      channel_reg <= channel_next;
    end
  end

endmodule

### rtl/pnm_hdr_out_stage.sv
module pnm_hdr_out_stage
  import pnm_hdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  hdr_result_t res,
  output logic        free,
  output logic        result_valid,
  input  logic        result_ready,
  output hdr_result_t result
);

  assign free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (free) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      result <= res;
    end
  end

endmodule

### rtl/pnm_header_parser_top.sv
// Binary PNM header parser. Each input beat (data byte, end of file or start)
// yields exactly one result beat carrying the parse status and, on completion,
// width, height, saturated max value, channel count and bytes per value.
// Throughput is one beat per cycle unless result_ready stalls the output. A
// beat passes the input register, then the combinational parse step, then the
// result register. The per-byte state update, including the multiply-by-ten
// digit accumulate, is combinational within that parse step. NUMBER_WIDTH
// sets the wrap width of the header numbers.
module pnm_header_parser_top
  import pnm_hdr_pkg::*;
#(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  hdr_item_t   item,
  output logic        result_valid,
  input  logic        result_ready,
  output hdr_result_t result
);

  logic        held_valid;
  hdr_item_t   held;
  logic        free;
  logic        go;
  hdr_result_t res;

  assign go = held_valid && free;

  pnm_hdr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .take       (go),
    .held_valid (held_valid),
    .held       (held)
  );

  pnm_hdr_core #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .item (held),
    .res  (res)
  );

  pnm_hdr_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (go),
    .res          (res),
    .free         (free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

### rtl/pnm_hdr_checker.sv
module pnm_hdr_checker
  import pnm_hdr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input hdr_result_t result
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_COMPLETE |->
      result.image_width == '0 && result.image_height == '0 &&
      result.max_value == '0 && result.channels == '0 && result.value_bytes == '0)
    else $error("header fields set without completion");

  a_complete_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_COMPLETE |->
      (result.channels == CHAN_GREY || result.channels == CHAN_COLOR) &&
      result.value_bytes == value_bytes_of(result.max_value))
    else $error("inconsistent completed header");

endmodule

bind pnm_header_parser_top pnm_hdr_checker u_pnm_hdr_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
